// ===== rtl/core/ssbu_pkg.sv =====
// shared types and constants for the spectrum segment bit unpacker
`timescale 1ns / 1ps
`default_nettype none

package ssbu_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned WID_W    = 5;
  localparam int unsigned TOTAL_W  = 13;
  localparam int unsigned HDR_W    = 12;
  localparam int unsigned HCNT_W   = 4;
  localparam int unsigned BITS_W   = 4;

  // segment header length in bits
  localparam logic [HCNT_W-1:0] HDR_BITS = 4'd12;

  // saturation limit of the decoded sample count
  localparam logic [TOTAL_W-1:0] CNT_MAX = 13'h1FFF;

  // spectrum length after reset
  localparam logic [TOTAL_W-1:0] LEN_RESET = 13'd2048;

  // bits in one input byte
  localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;

  // one queued input request
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
  } byte_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssbu_channels.sv =====
// valid/ready channel interfaces of the spectrum segment bit unpacker
`timescale 1ns / 1ps
`default_nettype none

// compressed byte requests
interface ssbu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

// decoded result requests
interface ssbu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic [6:0]         repeat_count;
  logic [12:0]        decoded_total;
  logic               last;

  modport source (output valid, sample, repeat_count, decoded_total, last, input ready);
  modport sink   (input valid, sample, repeat_count, decoded_total, last, output ready);
endinterface

// spectrum length register writes
interface ssbu_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] spectrum_length;

  modport source (output valid, spectrum_length, input ready);
  modport sink   (input valid, spectrum_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ssbu_byte_queue.sv =====
// front end: accepts byte requests into a short queue
`timescale 1ns / 1ps
`default_nettype none

module ssbu_byte_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  ssbu_in_if.sink                  req,
  output      logic                head_valid,
  output      ssbu_pkg::byte_req_t head,
  input  wire logic                head_pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ssbu_pkg::byte_req_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;

  // handshake
  assign req.ready  = (fill != FULL_CNT);
  assign push       = req.valid && req.ready;
  assign head_valid = (fill != '0);
  assign pop        = head_pop && head_valid;
  assign head       = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data_byte: req.data_byte, first_byte: req.first_byte};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssbu_bit_engine.sv =====
// back end: walks the bit stream one bit a cycle while the result slot is free, and emits results
`timescale 1ns / 1ps
`default_nettype none

module ssbu_bit_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [12:0]         spectrum_length,
  input  wire logic                head_valid,
  input  wire ssbu_pkg::byte_req_t head,
  output      logic                head_pop,
  ssbu_out_if.source               res
);

  // current byte
  logic [ssbu_pkg::BYTE_W-1:0]  cur_byte;
  logic [ssbu_pkg::BITS_W-1:0]  bits_left;

  // decoder state
  logic [ssbu_pkg::HDR_W-1:0]   header_bits, header_bits_next;
  logic [ssbu_pkg::HCNT_W-1:0]  header_bit_count, header_bit_count_next;
  logic [ssbu_pkg::CNT_W-1:0]   segment_remaining, segment_remaining_next;
  logic [ssbu_pkg::WID_W-1:0]   value_width, value_width_next;
  logic [ssbu_pkg::SUM_W-1:0]   value_shift, value_shift_next;
  logic [ssbu_pkg::WID_W-1:0]   value_bit_count, value_bit_count_next;
  logic [ssbu_pkg::SUM_W-1:0]   running_sum, running_sum_next;
  logic [ssbu_pkg::TOTAL_W-1:0] sample_count, sample_count_next;
  logic                         finished, finished_next;

  // per-bit decode
  logic                         step;
  logic                         load;
  logic                         bit_in;
  logic                         in_values;
  logic                         emit;
  logic [ssbu_pkg::CNT_W-1:0]   emit_rep;
  logic [ssbu_pkg::CNT_W-1:0]   add_n;
  logic [ssbu_pkg::TOTAL_W:0]   count_sum;
  logic [ssbu_pkg::WID_W-1:0]   vbc_inc;
  logic [ssbu_pkg::HCNT_W-1:0]  hcnt_inc;
  logic [ssbu_pkg::HDR_W-1:0]   hdr_shifted;

  // a bit moves when one is held and the result slot is free
  assign step     = (bits_left != '0) && (!res.valid || res.ready);
  assign load     = head_valid &&
                    ((bits_left == '0) || ((bits_left == ssbu_pkg::BITS_W'(1)) && step));
  assign head_pop = load;
  assign bit_in   = cur_byte[ssbu_pkg::BYTE_W-1];

  assign in_values   = (segment_remaining != '0) && (value_width != '0);
  assign vbc_inc     = value_bit_count + ssbu_pkg::WID_W'(1);
  assign hcnt_inc    = header_bit_count + ssbu_pkg::HCNT_W'(1);
  assign hdr_shifted = {header_bits[ssbu_pkg::HDR_W-2:0], bit_in};

  // saturating sample count
  always_comb begin
    count_sum = {1'b0, sample_count} + {{(ssbu_pkg::TOTAL_W + 1 - ssbu_pkg::CNT_W){1'b0}}, add_n};
    if (count_sum > {1'b0, ssbu_pkg::CNT_MAX}) begin
      sample_count_next = ssbu_pkg::CNT_MAX;
    end else begin
      sample_count_next = count_sum[ssbu_pkg::TOTAL_W-1:0];
    end
  end

  // next state of one bit
  always_comb begin
    header_bits_next       = header_bits;
    header_bit_count_next  = header_bit_count;
    segment_remaining_next = segment_remaining;
    value_width_next       = value_width;
    value_shift_next       = value_shift;
    value_bit_count_next   = value_bit_count;
    running_sum_next       = running_sum;
    finished_next          = finished;
    add_n                  = '0;
    emit                   = 1'b0;
    emit_rep               = ssbu_pkg::CNT_W'(1);
    priority if (finished) begin
      // rest of the stream is ignored
    end else if (!in_values && (header_bit_count == '0) &&
                 (sample_count >= spectrum_length)) begin
      finished_next = 1'b1;
    end else if (in_values) begin
      if (value_bit_count == '0) begin
        value_shift_next = {ssbu_pkg::SUM_W{bit_in}};
      end else begin
        value_shift_next = {value_shift[ssbu_pkg::SUM_W-2:0], bit_in};
      end
      value_bit_count_next = vbc_inc;
      if (vbc_inc >= value_width) begin
        value_bit_count_next   = '0;
        running_sum_next       = running_sum + value_shift_next;
        add_n                  = ssbu_pkg::CNT_W'(1);
        segment_remaining_next = segment_remaining - ssbu_pkg::CNT_W'(1);
        emit                   = 1'b1;
      end
    end else begin
      header_bits_next      = hdr_shifted;
      header_bit_count_next = hcnt_inc;
      if (hcnt_inc >= ssbu_pkg::HDR_BITS) begin
        header_bits_next      = '0;
        header_bit_count_next = '0;
        value_bit_count_next  = '0;
        value_shift_next      = '0;
        value_width_next      = hdr_shifted[ssbu_pkg::WID_W-1:0];
        if (hdr_shifted[ssbu_pkg::WID_W-1:0] == '0) begin
          segment_remaining_next = '0;
          if (hdr_shifted[ssbu_pkg::HDR_W-1:ssbu_pkg::WID_W] != '0) begin
            add_n    = hdr_shifted[ssbu_pkg::HDR_W-1:ssbu_pkg::WID_W];
            emit     = 1'b1;
            emit_rep = hdr_shifted[ssbu_pkg::HDR_W-1:ssbu_pkg::WID_W];
          end
        end else begin
          segment_remaining_next = hdr_shifted[ssbu_pkg::HDR_W-1:ssbu_pkg::WID_W];
        end
      end
    end
  end

  // byte shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
    end else if (load) begin
      bits_left <= ssbu_pkg::BYTE_BITS;
    end else if (step) begin
      bits_left <= bits_left - ssbu_pkg::BITS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_byte <= head.data_byte;
    end else if (step) begin
      cur_byte <= {cur_byte[ssbu_pkg::BYTE_W-2:0], 1'b0};
    end
  end

  // decoder state, restart on a first byte
  always_ff @(posedge clk) begin
    if (rst || (load && head.first_byte)) begin
      header_bits       <= '0;
      header_bit_count  <= '0;
      segment_remaining <= '0;
      value_width       <= '0;
      value_shift       <= '0;
      value_bit_count   <= '0;
      running_sum       <= '0;
      sample_count      <= '0;
      finished          <= 1'b0;
    end else if (step) begin
      header_bits       <= header_bits_next;
      header_bit_count  <= header_bit_count_next;
      segment_remaining <= segment_remaining_next;
      value_width       <= value_width_next;
      value_shift       <= value_shift_next;
      value_bit_count   <= value_bit_count_next;
      running_sum       <= running_sum_next;
      sample_count      <= sample_count_next;
      finished          <= finished_next;
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (step && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res.sample        <= $signed(running_sum_next);
      res.repeat_count  <= emit_rep;
      res.decoded_total <= sample_count_next;
      res.last          <= (sample_count_next >= spectrum_length);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spectrum_segment_bit_unpacker_core.sv =====
// Spectrum segment bit unpacker: takes compressed bytes, MSB first, and decodes
// 12-bit segment headers (7-bit count, 5-bit width) followed by signed deltas
// that build a 32-bit wrapping running sum; each result is one sample, or one
// run item for a zero-width segment. The bit decoder takes one bit a cycle,
// each bit giving at most one result; a result held on the output stalls the
// decoder, while the QUEUE_DEPTH-entry byte queue in front keeps taking bytes.
// first_byte restarts decoding at that byte. The user must write the
// spectrum_length register via the cfg channel only when idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_segment_bit_unpacker_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ssbu_in_if.sink    byte_in,
  ssbu_out_if.source result_out,
  ssbu_cfg_if.sink   cfg
);

  logic [ssbu_pkg::TOTAL_W-1:0] spectrum_length;
  logic                         head_valid;
  logic                         head_pop;
  ssbu_pkg::byte_req_t          head;

  // length register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spectrum_length <= ssbu_pkg::LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      spectrum_length <= cfg.spectrum_length;
    end
  end

  // front end
  ssbu_byte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .req        (byte_in),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // back end
  ssbu_bit_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .spectrum_length (spectrum_length),
    .head_valid      (head_valid),
    .head            (head),
    .head_pop        (head_pop),
    .res             (result_out)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ssbu_checker.sv =====
// port-level checks for the spectrum segment bit unpacker
`timescale 1ns / 1ps
`default_nettype none

module ssbu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] sample,
  input wire logic [6:0]  repeat_count,
  input wire logic [12:0] decoded_total
);

  // nothing comes out right after reset
  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result request right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(sample) &&
      $stable(repeat_count) && $stable(decoded_total))
    else $error("stalled result changed");

  // every item stands for at least one sample
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (repeat_count != 7'd0) && (decoded_total != 13'd0))
    else $error("result with no samples");

  // the running total covers the run of this item
  a_total_covers_run: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (decoded_total >= {6'd0, repeat_count}))
    else $error("decoded total below repeat count");

endmodule

bind spectrum_segment_bit_unpacker_core ssbu_checker u_ssbu_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result_out.valid),
  .res_ready     (result_out.ready),
  .sample        (result_out.sample),
  .repeat_count  (result_out.repeat_count),
  .decoded_total (result_out.decoded_total)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the spectrum segment bit unpacker core
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 3;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_SHOWN      = 10;
  localparam int SEG_BIT_CAP    = 320;
  localparam int STREAM_BIT_CAP = 400;
  localparam int PHASE_BYTES    = 47;

  // receiver stall patterns
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_ONE_IN_FOUR,
    STALL_LIGHT
  } stall_mode_t;

  // one decoded sample as seen on the result channel
  typedef struct packed {
    logic signed [ssbu_pkg::SUM_W-1:0] sum;
    logic [ssbu_pkg::CNT_W-1:0]        repeat_count;
    logic [ssbu_pkg::TOTAL_W-1:0]      decoded_total;
    logic                              last;
  } sample_rec_t;

  // bit-level predictor of the unpacker plus the queue of samples it expects
  class sample_scoreboard;
    logic [ssbu_pkg::TOTAL_W-1:0] length;
    logic [ssbu_pkg::HDR_W-1:0]   hdr;
    logic [ssbu_pkg::HCNT_W-1:0]  hdr_count;
    logic [ssbu_pkg::CNT_W-1:0]   seg_left;
    logic [ssbu_pkg::WID_W-1:0]   val_width;
    logic [ssbu_pkg::SUM_W-1:0]   val_acc;
    logic [ssbu_pkg::WID_W-1:0]   val_count;
    logic [ssbu_pkg::SUM_W-1:0]   run_sum;
    logic [ssbu_pkg::TOTAL_W-1:0] total;
    bit                           done;
    sample_rec_t                  expected_samples[$];
    int                           checked;
    int                           mismatches;

    function new();
      length     = ssbu_pkg::LEN_RESET;
      checked    = 0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      hdr       = '0;
      hdr_count = '0;
      seg_left  = '0;
      val_width = '0;
      val_acc   = '0;
      val_count = '0;
      run_sum   = '0;
      total     = '0;
      done      = 1'b0;
    endfunction

    function void set_length(logic [ssbu_pkg::TOTAL_W-1:0] v);
      length = v;
    endfunction

    // saturating add into the decoded sample count
    function void add_total(int n);
      int t;
      t = int'(total) + n;
      total = (t > int'(ssbu_pkg::CNT_MAX)) ? ssbu_pkg::CNT_MAX : t[ssbu_pkg::TOTAL_W-1:0];
    endfunction

    function void queue_sample(logic [ssbu_pkg::CNT_W-1:0] rep);
      sample_rec_t r;
      r.sum           = run_sum;
      r.repeat_count  = rep;
      r.decoded_total = total;
      r.last          = (total >= length);
      expected_samples.push_back(r);
    endfunction

    // walk the byte MSB first and queue every sample it produces
    function void note_byte(logic [ssbu_pkg::BYTE_W-1:0] data, logic is_first);
      bit                         b;
      bit                         in_values;
      logic [ssbu_pkg::CNT_W-1:0] cnt;
      logic [ssbu_pkg::WID_W-1:0] wid;
      if (is_first) restart();
      for (int i = ssbu_pkg::BYTE_W - 1; i >= 0; i--) begin
        b = data[i];
        in_values = (seg_left != 0) && (val_width != 0);
        if (done) break;
        // stop only at a segment boundary once the length is reached
        if (!in_values && hdr_count == 0 && total >= length) begin
          done = 1'b1;
          break;
        end
        if (in_values) begin
          if (val_count == 0) val_acc = b ? '1 : '0;
          else val_acc = {val_acc[ssbu_pkg::SUM_W-2:0], b};
          val_count++;
          if (val_count >= val_width) begin
            val_count = '0;
            run_sum  += val_acc;
            add_total(1);
            seg_left--;
            queue_sample(ssbu_pkg::CNT_W'(1));
          end
        end else begin
          hdr = {hdr[ssbu_pkg::HDR_W-2:0], b};
          hdr_count++;
          if (hdr_count >= ssbu_pkg::HDR_BITS) begin
            cnt       = hdr[ssbu_pkg::HDR_W-1:ssbu_pkg::WID_W];
            wid       = hdr[ssbu_pkg::WID_W-1:0];
            hdr_count = '0;
            hdr       = '0;
            val_count = '0;
            val_acc   = '0;
            val_width = wid;
            if (wid == 0) begin
              // zero width: one run item, empty if the count is zero
              seg_left = '0;
              if (cnt != 0) begin
                add_total(cnt);
                queue_sample(cnt);
              end
            end else begin
              seg_left = cnt;
            end
          end
        end
      end
    endfunction

    function void check_result(sample_rec_t got);
      sample_rec_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected sample %0d repeat %0d total %0d last %0b",
                   got.sum, got.repeat_count, got.decoded_total, got.last);
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (got.sum !== want.sum || got.repeat_count !== want.repeat_count ||
          got.decoded_total !== want.decoded_total || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("sample #%0d mismatch: expected sum %0d repeat %0d total %0d last %0b",
                   checked, want.sum, want.repeat_count, want.decoded_total, want.last);
          $display("                       got sum %0d repeat %0d total %0d last %0b",
                   got.sum, got.repeat_count, got.decoded_total, got.last);
        end
      end
    endfunction

    function int outstanding();
      return expected_samples.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ssbu_in_if  byte_if ();
  ssbu_out_if res_if ();
  ssbu_cfg_if cfg_if ();

  spectrum_segment_bit_unpacker_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .result_out (res_if),
    .cfg        (cfg_if)
  );

  sample_scoreboard sb;
  bit               hold_req;
  int               burst_left;
  int               bytes_pushed;
  int               streams_sent;
  int               settings_used;
  bit               stream_bits[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[spectrum_segment_bit_unpacker_core] ERROR");
    $finish;
  end

  // result receiver: changing stall patterns plus one long hold-off on request
  initial begin : result_sink
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          tick;
    res_if.ready = 1'b0;
    mode         = STALL_NONE;
    mode_left    = 0;
    hold_left    = 0;
    tick         = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (mode)
          STALL_NONE:        res_if.ready <= 1'b1;
          STALL_COIN:        res_if.ready <= ($urandom_range(0, 1) == 1);
          STALL_ONE_IN_FOUR: res_if.ready <= (tick % 4 == 0);
          default:           res_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // handshake monitor feeding the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.sample, res_if.repeat_count, res_if.decoded_total,
                         res_if.last});
      if (byte_if.valid && byte_if.ready)
        sb.note_byte(byte_if.data_byte, byte_if.first_byte);
    end
  end

  // offer one byte request, idling between bursts; leaves valid high
  task automatic push_byte(input logic [ssbu_pkg::BYTE_W-1:0] d, input bit lead);
    if (burst_left == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= d;
    byte_if.first_byte <= lead;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_pushed++;
  endtask

  // drop valid and wait until every expected sample is out and the queue drained
  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [ssbu_pkg::TOTAL_W-1:0] v);
    cfg_if.valid           <= 1'b1;
    cfg_if.spectrum_length <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_length(v);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic add_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic add_header(input int cnt, input int wid);
    add_bits((cnt << ssbu_pkg::WID_W) | wid, ssbu_pkg::HDR_W);
  endtask

  // pad the bit stream to whole bytes and send it
  task automatic send_stream(input bit restart);
    logic [ssbu_pkg::BYTE_W-1:0] b;
    bit                          lead;
    while (stream_bits.size() % ssbu_pkg::BYTE_W != 0)
      stream_bits.push_back($urandom_range(0, 1));
    lead = restart;
    while (stream_bits.size() > 0) begin
      for (int k = 0; k < ssbu_pkg::BYTE_W; k++)
        b = {b[ssbu_pkg::BYTE_W-2:0], stream_bits.pop_front()};
      push_byte(b, lead);
      lead = 1'b0;
    end
    streams_sent++;
  endtask

  // one random segment; made returns the samples it stands for
  task automatic add_random_segment(input int run_pct, output int made);
    int          kind;
    int          cnt;
    int          wid;
    logic [31:0] v;
    kind = $urandom_range(0, 99);
    if (kind < run_pct) begin
      cnt = $urandom_range(0, 1) ? $urandom_range(1, 10) : $urandom_range(64, 127);
      add_header(cnt, 0);
      made = cnt;
    end else if (kind < run_pct + 5) begin
      add_header(0, $urandom_range(0, 31));
      made = 0;
    end else begin
      case ($urandom_range(0, 3))
        0:       wid = 1;
        1:       wid = 31;
        default: wid = $urandom_range(1, 31);
      endcase
      cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
      if (cnt * wid > SEG_BIT_CAP) cnt = SEG_BIT_CAP / wid;
      add_header(cnt, wid);
      for (int k = 0; k < cnt; k++) begin
        // most positive and most negative deltas now and then
        case ($urandom_range(0, 9))
          0:       v = 32'h7FFF_FFFF >> (32 - wid);
          1:       v = 32'h1 << (wid - 1);
          default: v = $urandom;
        endcase
        add_bits(v, wid);
      end
      made = cnt;
    end
  endtask

  // well-formed stream, sometimes cut short, sometimes with trailing bytes
  task automatic random_stream(input int len);
    int want;
    int made;
    int got;
    int run_pct;
    want    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len) : len;
    run_pct = (len > 300) ? 80 : 20;
    made    = 0;
    do begin
      add_random_segment(run_pct, got);
      made += got;
    end while (made < want && stream_bits.size() < STREAM_BIT_CAP);
    send_stream(1'b1);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        push_byte(ssbu_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
  endtask

  // stimulus
  initial begin : stimulus
    int lengths[6];
    int budget_end;
    sb                     = new();
    rst                    = 1'b1;
    hold_req               = 1'b0;
    burst_left             = 0;
    bytes_pushed           = 0;
    streams_sent           = 0;
    settings_used          = 0;
    byte_if.valid          = 1'b0;
    byte_if.data_byte      = '0;
    byte_if.first_byte     = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.spectrum_length = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one-bit deltas, run, empty segment, widest deltas at both ends,
    // overshooting run, ignored bytes after the end, then a restart
    write_length(ssbu_pkg::TOTAL_W'(20));
    add_header(2, 1);
    add_bits(0, 1);
    add_bits(1, 1);
    add_header(5, 0);
    add_header(0, 7);
    add_header(1, 31);
    add_bits(32'h3FFF_FFFF, 31);
    add_header(1, 31);
    add_bits(32'h4000_0000, 31);
    add_header(127, 0);
    send_stream(1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    add_header(8, 1);
    add_bits(32'hA5, 8);
    send_stream(1'b1);
    wait_idle();

    // random phases over several length settings, extremes included
    lengths[0] = 1;
    lengths[1] = $urandom_range(2, 50);
    lengths[2] = 4096;
    lengths[3] = $urandom_range(51, 700);
    lengths[4] = $urandom_range(2, 20);
    lengths[5] = $urandom_range(1, 4096);
    foreach (lengths[p]) begin
      write_length(ssbu_pkg::TOTAL_W'(lengths[p]));
      budget_end = bytes_pushed + PHASE_BYTES;
      // long result hold-off while bytes keep coming
      if (p == 1) hold_req = 1'b1;
      while (bytes_pushed < budget_end) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4))
            push_byte(ssbu_pkg::BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        else
          random_stream(lengths[p]);
      end
      wait_idle();
    end

    $display("run covered %0d byte requests in %0d streams under %0d length settings",
             bytes_pushed, streams_sent, settings_used);
    $display("%0d samples checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[spectrum_segment_bit_unpacker_core] OK");
    end else begin
      $display("[spectrum_segment_bit_unpacker_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ssbu_pkg.sv
rtl/core/ssbu_channels.sv
rtl/core/ssbu_byte_queue.sv
rtl/core/ssbu_bit_engine.sv
rtl/core/spectrum_segment_bit_unpacker_core.sv
rtl/core/ssbu_checker.sv
tb/testbench.sv
